### rtl/core/kuwahara_filter_assert.svh
// assertion macros used by the kuwahara filter back end
`ifndef KUWAHARA_FILTER_ASSERT_SVH
`define KUWAHARA_FILTER_ASSERT_SVH

// condition must never hold at a clock edge out of reset
`define KF_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// antecedent at an edge implies consequent at the same edge
`define KF_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/kf_pkg.sv
package kf_pkg;

  localparam int unsigned CFG_DW       = 13;
  localparam int unsigned CFG_IW       = 1;
  localparam int unsigned WIDTH_REG_W  = 12;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned JOB_COL_W    = 13;
  localparam int unsigned JOB_SLOT_W   = 4;
  localparam int unsigned PIX_MAX      = 255;

  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
  } out_item_t;

  // one owed output, as handed from the front to the back
  typedef struct packed {
    logic [JOB_COL_W-1:0]  col;
    logic [JOB_SLOT_W-1:0] top_slot;
    logic [JOB_SLOT_W-1:0] ctr_slot;
    logic                  border;
    logic                  frame_end;
  } job_t;

  // line store write port
  typedef struct packed {
    logic                  en;
    logic [JOB_SLOT_W-1:0] slot;
    logic [JOB_COL_W-1:0]  col;
    logic [7:0]            data;
  } wr_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_WAIT,
    BK_CALC,
    BK_DIV,
    BK_DONE
  } bk_state_e;

endpackage

### rtl/core/kf_front.sv
module kf_front import kf_pkg::*; #(
  parameter int unsigned KERNEL     = 5,
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              push_i,
  input  in_item_t          in_item_i,
  input  logic              q_empty_i,
  input  logic              back_busy_i,
  output logic              full_o,
  output logic              job_push_o,
  output job_t              job_o,
  output wr_t               wr_o
);

  localparam int unsigned HALF = KERNEL / 2;
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned SLW  = $clog2(KERNEL);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic                    cfg_pend_q;
  logic [WW-1:0]           w_q;
  logic [HW-1:0]           h_q;
  logic [PW-1:0]           total_q, delay_q;
  logic [31:0]             w_eff, h_eff;

  logic [CW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [SLW-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic [RW-1:0]  out_row_q, out_row_d;
  logic [PW-1:0]  rcv_q, rcv_d, opos_q, opos_d;
  logic           frame_full_q, frame_full_d;

  logic           accept, rst_px;
  logic [CW-1:0]  ic, ocol, ocol_n;
  logic [SLW-1:0] islot, oslot, islot_n, oslot_n;
  logic [RW-1:0]  orow, orow_n;
  logic [PW-1:0]  rcv, opos;
  logic           border_w;
  logic [SLW-1:0] top_slot_w;

  assign full_o = cfg_pend_q | ~q_empty_i | back_busy_i;
  assign accept = push_i & ~full_o;

  // clamped geometry
  always_comb begin
    w_eff = 32'(width_q);
    if (w_eff == 32'd0) w_eff = 32'd1;
    if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
    h_eff = 32'(height_q);
    if (h_eff == 32'd0) h_eff = 32'd1;
    if (h_eff > MAX_HEIGHT) h_eff = MAX_HEIGHT;
  end

  always_ff @(posedge clk_i) begin
    w_q     <= WW'(w_eff);
    h_q     <= HW'(h_eff);
    total_q <= PW'(w_eff * h_eff);
    delay_q <= PW'(HALF * w_eff + HALF);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RESET;
      height_q   <= HEIGHT_RESET;
      cfg_pend_q <= 1'b1;
    end else begin
      cfg_pend_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[WIDTH_REG_W-1:0];
          REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // a pixel after a complete frame starts the next one
  always_comb begin
    rst_px = (in_item_i.op == OP_PIXEL) && frame_full_q;
    ic     = rst_px ? '0 : in_col_q;
    islot  = rst_px ? '0 : in_slot_q;
    rcv    = rst_px ? '0 : rcv_q;
    opos   = rst_px ? '0 : opos_q;
    ocol   = rst_px ? '0 : out_col_q;
    orow   = rst_px ? '0 : out_row_q;
    oslot  = rst_px ? '0 : out_slot_q;
  end

  always_comb begin
    islot_n = islot;
    if (32'(ic) + 32'd1 >= 32'(w_q)) begin
      if (32'(islot) == KERNEL - 1) islot_n = '0;
      else                          islot_n = islot + SLW'(1);
    end
    oslot_n = oslot;
    orow_n  = orow;
    ocol_n  = ocol + CW'(1);
    if (32'(ocol) + 32'd1 >= 32'(w_q)) begin
      ocol_n = '0;
      orow_n = orow + RW'(1);
      if (32'(oslot) == KERNEL - 1) oslot_n = '0;
      else                          oslot_n = oslot + SLW'(1);
    end
    border_w = (32'(orow) < HALF) || (32'(orow) + HALF >= 32'(h_q)) ||
               (32'(ocol) < HALF) || (32'(ocol) + HALF >= 32'(w_q));
    if (32'(oslot) >= HALF) top_slot_w = SLW'(32'(oslot) - HALF);
    else                    top_slot_w = SLW'(32'(oslot) + KERNEL - HALF);
  end

  always_comb begin
    in_col_d     = in_col_q;
    in_slot_d    = in_slot_q;
    rcv_d        = rcv_q;
    opos_d       = opos_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    out_slot_d   = out_slot_q;
    frame_full_d = frame_full_q;
    job_push_o   = 1'b0;
    job_o        = '0;
    wr_o         = '0;
    job_o.col      = JOB_COL_W'(ocol);
    job_o.top_slot = JOB_SLOT_W'(top_slot_w);
    job_o.ctr_slot = JOB_SLOT_W'(oslot);
    job_o.border   = border_w;
    if (cfg_we_i) begin
      in_col_d     = '0;
      in_slot_d    = '0;
      rcv_d        = '0;
      opos_d       = '0;
      out_col_d    = '0;
      out_row_d    = '0;
      out_slot_d   = '0;
      frame_full_d = 1'b0;
    end else if (accept && in_item_i.op == OP_PIXEL) begin
      wr_o.en      = 1'b1;
      wr_o.slot    = JOB_SLOT_W'(islot);
      wr_o.col     = JOB_COL_W'(ic);
      wr_o.data    = in_item_i.pixel_in;
      in_col_d     = (32'(ic) + 32'd1 >= 32'(w_q)) ? '0 : ic + CW'(1);
      in_slot_d    = islot_n;
      rcv_d        = rcv + PW'(1);
      frame_full_d = (rcv + PW'(1)) >= total_q;
      opos_d       = opos;
      out_col_d    = ocol;
      out_row_d    = orow;
      out_slot_d   = oslot;
      if ((rcv + PW'(1)) > delay_q) begin
        job_push_o = 1'b1;
        opos_d     = opos + PW'(1);
        out_col_d  = ocol_n;
        out_row_d  = orow_n;
        out_slot_d = oslot_n;
      end
    end else if (accept && frame_full_q && opos_q < total_q) begin
      job_push_o = 1'b1;
      if (opos_q + PW'(1) >= total_q) begin
        // last transaction of the frame: positions back to zero
        job_o.frame_end = 1'b1;
        in_col_d     = '0;
        in_slot_d    = '0;
        rcv_d        = '0;
        opos_d       = '0;
        out_col_d    = '0;
        out_row_d    = '0;
        out_slot_d   = '0;
        frame_full_d = 1'b0;
      end else begin
        opos_d     = opos_q + PW'(1);
        out_col_d  = ocol_n;
        out_row_d  = orow_n;
        out_slot_d = oslot_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q     <= '0;
      in_slot_q    <= '0;
      rcv_q        <= '0;
      opos_q       <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      out_slot_q   <= '0;
      frame_full_q <= 1'b0;
    end else begin
      in_col_q     <= in_col_d;
      in_slot_q    <= in_slot_d;
      rcv_q        <= rcv_d;
      opos_q       <= opos_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      out_slot_q   <= out_slot_d;
      frame_full_q <= frame_full_d;
    end
  end

endmodule

### rtl/core/kf_job_fifo.sv
module kf_job_fifo import kf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = slot_q[rptr_q];
  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/core/kf_back.sv
`include "kuwahara_filter_assert.svh"

module kf_back import kf_pkg::*; #(
  parameter int unsigned KERNEL    = 5,
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_vld_i,
  output logic      job_pop_o,
  input  wr_t       wr_i,
  output logic      busy_o,
  output out_item_t out_item_o,
  output logic      empty_o,
  input  logic      pop_i
);

  localparam int unsigned HALF      = KERNEL / 2;
  localparam int unsigned QSIDE     = (KERNEL + 1) / 2;
  localparam int unsigned QN        = QSIDE * QSIDE;
  localparam int unsigned CW        = $clog2(MAX_WIDTH);
  localparam int unsigned SLW       = $clog2(KERNEL);
  localparam int unsigned MEM_DEPTH = KERNEL * (2 ** CW);
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned SW        = $clog2(PIX_MAX * QN + 1);
  localparam int unsigned QW        = $clog2(PIX_MAX * PIX_MAX * QN + 1);
  localparam int unsigned NW        = $clog2(PIX_MAX * PIX_MAX * QN * QN + 1);
  // reciprocal of the quadrant size, exact for every SW-bit sum
  localparam int unsigned RSH       = SW + $clog2(QN);
  localparam longint unsigned RECIP = ((longint'(1) << RSH) + QN - 1) / QN;
  localparam int unsigned PRW       = 2 * SW + 2;

  logic [7:0]     line_store_q [MEM_DEPTH];
  logic [7:0]     rdata_q;
  logic [AW-1:0]  rd_addr, wr_addr;

  bk_state_e      state_q, state_d;
  job_t           job_q;
  logic [SLW-1:0] ri_q, ci_q, slot_q, rd_ri_q, rd_ci_q;
  logic [CW-1:0]  col_q;
  logic           rd_vld_q;
  logic [SW-1:0]  sum_q [4];
  logic [QW-1:0]  sq_q [4];
  logic [2:0]     idx_q;
  logic [NW-1:0]  num_q, best_q, num_w;
  logic [SW-1:0]  nsum_q, bsum_q;
  logic [7:0]     res_q;
  logic           out_vld_q, out_we;
  out_item_t      out_q;
  logic           last_rd;
  logic [15:0]    pix_sq;
  logic [3:0]     memb;
  logic [PRW-1:0] prod_w;
  logic [7:0]     quot_w;
  logic [SW+7:0]  quot_rem_w;
  logic           mean_ok_w;

  assign rd_addr = AW'({slot_q, col_q});
  assign wr_addr = AW'({wr_i.slot[SLW-1:0], wr_i.col[CW-1:0]});

  always_ff @(posedge clk_i) begin
    if (wr_i.en) line_store_q[wr_addr] <= wr_i.data;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= line_store_q[rd_addr];
  end

  assign last_rd = job_q.border ||
                   (32'(ri_q) == KERNEL - 1 && 32'(ci_q) == KERNEL - 1);
  assign busy_o     = (state_q != BK_IDLE);
  assign empty_o    = ~out_vld_q;
  assign out_item_o = out_q;

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    out_we    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (job_vld_i) begin
          job_pop_o = 1'b1;
          state_d   = BK_READ;
        end
      end
      BK_READ: if (last_rd) state_d = BK_WAIT;
      BK_WAIT: state_d = job_q.border ? BK_DONE : BK_CALC;
      BK_CALC: if (idx_q == 3'd4) state_d = BK_DIV;
      BK_DIV:  state_d = BK_DONE;
      BK_DONE: begin
        if (!out_vld_q || pop_i) begin
          out_we  = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == BK_READ);
      if (out_we)     out_vld_q <= 1'b1;
      else if (pop_i) out_vld_q <= 1'b0;
    end
  end

  // quadrant membership of the pixel now on the read data
  always_comb begin
    pix_sq  = {8'd0, rdata_q} * {8'd0, rdata_q};
    memb[0] = (32'(rd_ri_q) < QSIDE) && (32'(rd_ci_q) < QSIDE);
    memb[1] = (32'(rd_ri_q) < QSIDE) && (32'(rd_ci_q) >= HALF);
    memb[2] = (32'(rd_ri_q) >= HALF) && (32'(rd_ci_q) < QSIDE);
    memb[3] = (32'(rd_ri_q) >= HALF) && (32'(rd_ci_q) >= HALF);
    // n*Q - S*S is n squared times the variance
    num_w   = NW'(QN) * NW'(sq_q[idx_q[1:0]]) -
              NW'(sum_q[idx_q[1:0]]) * NW'(sum_q[idx_q[1:0]]);
    // mean of the chosen quadrant by reciprocal multiplication
    prod_w     = PRW'(bsum_q) * PRW'(RECIP);
    quot_w     = prod_w[RSH +: 8];
    quot_rem_w = (SW + 8)'(bsum_q) - (SW + 8)'(res_q) * (SW + 8)'(QN);
    mean_ok_w  = quot_rem_w < (SW + 8)'(QN);
  end

  always_ff @(posedge clk_i) begin
    rd_ri_q <= ri_q;
    rd_ci_q <= ci_q;
    if (out_we) begin
      out_q.pixel_out <= res_q;
      out_q.frame_end <= job_q.frame_end;
    end
    if (state_q == BK_IDLE && job_vld_i) begin
      for (int q = 0; q < 4; q++) begin
        sum_q[q] <= '0;
        sq_q[q]  <= '0;
      end
    end else if (rd_vld_q) begin
      for (int q = 0; q < 4; q++) begin
        if (memb[q]) begin
          sum_q[q] <= sum_q[q] + SW'(rdata_q);
          sq_q[q]  <= sq_q[q] + QW'(pix_sq);
        end
      end
    end
    case (state_q)
      BK_IDLE: begin
        if (job_vld_i) begin
          job_q <= job_i;
          ri_q  <= '0;
          ci_q  <= '0;
          idx_q <= '0;
          res_q <= '0;
          if (job_i.border) begin
            slot_q <= job_i.ctr_slot[SLW-1:0];
            col_q  <= job_i.col[CW-1:0];
          end else begin
            slot_q <= job_i.top_slot[SLW-1:0];
            col_q  <= job_i.col[CW-1:0] - CW'(HALF);
          end
        end
      end
      BK_READ: begin
        if (32'(ci_q) == KERNEL - 1) begin
          ci_q   <= '0;
          ri_q   <= ri_q + SLW'(1);
          slot_q <= (32'(slot_q) == KERNEL - 1) ? '0 : slot_q + SLW'(1);
          col_q  <= job_q.col[CW-1:0] - CW'(HALF);
        end else begin
          ci_q  <= ci_q + SLW'(1);
          col_q <= col_q + CW'(1);
        end
      end
      BK_WAIT: if (job_q.border) res_q <= rdata_q;
      BK_CALC: begin
        if (idx_q != 3'd4) begin
          num_q  <= num_w;
          nsum_q <= sum_q[idx_q[1:0]];
        end
        // later quadrant wins on equal variance
        if (idx_q != 3'd0 && (idx_q == 3'd1 || num_q <= best_q)) begin
          best_q <= num_q;
          bsum_q <= nsum_q;
        end
        idx_q <= idx_q + 3'd1;
      end
      BK_DIV: res_q <= quot_w;
      default: ;
    endcase
  end

  `KF_ASSERT_NEVER(a_wr_during_window, wr_i.en && state_q != BK_IDLE, "write mid window")
  `KF_ASSERT_NEVER(a_rd_tag_idle, rd_vld_q && state_q == BK_IDLE, "read valid while idle")
  `KF_ASSERT_IMPLY(a_quot_fits, state_q == BK_DONE && !job_q.border, mean_ok_w, "bad mean")

endmodule

### rtl/core/kuwahara_filter.sv
// Kuwahara filter over a raster stream of 8-bit grey pixels. Push pixel and drain
// transactions; results come back KERNEL/2 rows plus KERNEL/2 columns behind the
// input, with frame_end on the last pixel of a frame, delivered by drain
// transactions once the frame is complete. A transaction is taken only when the
// window unit is idle and its queue is empty. The time an interior result takes
// is set by the single read port of the line store (one window pixel per cycle),
// a five-step variance compare and a one-step reciprocal multiply for the mean;
// a result left waiting on the output stalls the next one. A register write
// blocks input and restarts the frame. The line store is not cleared at reset.
module kuwahara_filter import kf_pkg::*; #(
  parameter int unsigned KERNEL     = 5,
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              push,
  input  in_item_t          in_item_i,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output out_item_t         out_item_o
);

  logic job_push, q_empty, job_pop, back_busy;
  job_t job_in, job_out;
  wr_t  wr;

  kf_front #(
    .KERNEL    (KERNEL),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .q_empty_i  (q_empty),
    .back_busy_i(back_busy),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job_in),
    .wr_o       (wr)
  );

  kf_job_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job_in),
    .pop_i  (job_pop),
    .empty_o(q_empty),
    .job_o  (job_out)
  );

  kf_back #(
    .KERNEL   (KERNEL),
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (job_out),
    .job_vld_i (~q_empty),
    .job_pop_o (job_pop),
    .wr_i      (wr),
    .busy_o    (back_busy),
    .out_item_o(out_item_o),
    .empty_o   (empty),
    .pop_i     (pop)
  );

endmodule

### tb/sv/tb_kuwahara_filter.sv
`timescale 1ns / 1ps

module tb_kuwahara_filter;
  import kf_pkg::*;

  localparam int unsigned KERNEL     = 5;
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned HALF       = KERNEL / 2;
  localparam int unsigned QSIDE      = (KERNEL + 1) / 2;
  localparam int unsigned QCOUNT     = QSIDE * QSIDE;
  localparam int unsigned SETTLE     = 4 * (KERNEL * KERNEL + 17);
  localparam longint      CYCLE_LIMIT = 1500000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_wdata_i;
  logic              push;
  in_item_t          in_item_i;
  logic              full;
  logic              empty;
  logic              pop;
  out_item_t         out_item_o;

  kuwahara_filter #(
    .KERNEL    (KERNEL),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // filter state as the predictor sees it
  logic [7:0]              line_rows [KERNEL][MAX_WIDTH];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int unsigned             next_col;
  int unsigned             next_row;
  int unsigned             out_idx;
  bit                      frame_done;

  out_item_t   owed_pixels[$];
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_frames_out;
  int unsigned n_frames;
  longint      cycles;
  bit          steady;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned used_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned used_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    next_col   = 0;
    next_row   = 0;
    out_idx    = 0;
    frame_done = 0;
  endfunction

  function automatic logic [7:0] stored_at(int unsigned r, int unsigned c);
    if (c >= MAX_WIDTH) return 8'd0;
    return line_rows[r % KERNEL][c];
  endfunction

  function automatic logic [7:0] filtered_pixel(int unsigned j, int unsigned w,
                                                int unsigned h);
    int unsigned r;
    int unsigned c;
    int unsigned r0;
    int unsigned c0;
    longint      s;
    longint      sq;
    longint      spread;
    longint      best_spread;
    longint      best_sum;
    longint      v;
    r = j / w;
    c = j % w;
    best_spread = 0;
    best_sum = 0;
    if (r < HALF || r + HALF >= h || c < HALF || c + HALF >= w)
      return stored_at(r, c);
    // quadrants in order: top-left, top-right, bottom-left, bottom-right
    for (int q = 0; q < 4; q++) begin
      r0 = (q < 2) ? r - HALF : r;
      c0 = (q % 2 == 0) ? c - HALF : c;
      s = 0;
      sq = 0;
      for (int i = 0; i < QSIDE; i++)
        for (int k = 0; k < QSIDE; k++) begin
          v = stored_at(r0 + i, c0 + k);
          s += v;
          sq += v * v;
        end
      spread = QCOUNT * sq - s * s;
      if (q == 0 || spread <= best_spread) begin
        best_spread = spread;
        best_sum = s;
      end
    end
    return 8'(best_sum / QCOUNT);
  endfunction

  function automatic void predict_transaction(in_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned lag;
    int unsigned received;
    out_item_t   res;
    w = used_width();
    h = used_height();
    total = w * h;
    lag = HALF * w + HALF;
    if (it.op == OP_PIXEL) begin
      if (frame_done || next_col >= w || next_row >= h) restart_frame();
      line_rows[next_row % KERNEL][next_col] = it.pixel_in;
      received = next_row * w + next_col + 1;
      next_col++;
      if (next_col >= w) begin
        next_col = 0;
        next_row++;
      end
      if (received >= total) frame_done = 1;
      if (received > lag && out_idx < total) begin
        res.pixel_out = filtered_pixel(out_idx, w, h);
        res.frame_end = 1'b0;
        out_idx++;
        owed_pixels = {owed_pixels, res};
      end
    end else if (frame_done && out_idx < total) begin
      res.pixel_out = filtered_pixel(out_idx, w, h);
      out_idx++;
      res.frame_end = (out_idx >= total);
      if (res.frame_end) restart_frame();
      owed_pixels = {owed_pixels, res};
    end
  endfunction

  // result side: check each popped result and stall at random outside the steady phase
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (owed_pixels.size() == 0) begin
        $error("result with nothing owed: pixel_out %0d frame_end %0b",
               out_item_o.pixel_out, out_item_o.frame_end);
        n_errors++;
      end else begin
        if (out_item_o.pixel_out !== owed_pixels[0].pixel_out) begin
          $error("pixel_out: expected %0d, got %0d",
                 owed_pixels[0].pixel_out, out_item_o.pixel_out);
          n_errors++;
        end
        if (out_item_o.frame_end !== owed_pixels[0].frame_end) begin
          $error("frame_end: expected %0b, got %0b",
                 owed_pixels[0].frame_end, out_item_o.frame_end);
          n_errors++;
        end
        if (owed_pixels[0].frame_end) n_frames_out++;
        void'(owed_pixels.pop_front());
        n_checked++;
      end
    end
    pop <= steady || ($urandom_range(99) >= 13);
  end

  task automatic send_item(op_e op, logic [7:0] value);
    in_item_t it;
    it.op = op;
    it.pixel_in = value;
    if (!steady && $urandom_range(99) < 13) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    predict_transaction(it);
    n_sent++;
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    push <= 1'b0;
    @(posedge clk_i);
    while (owed_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
    else height_reg = data[HEIGHT_REG_W-1:0];
    restart_frame();
  endtask

  function automatic logic [7:0] texture_pixel(int unsigned style);
    case (style)
      0: return 8'(($urandom_range(3)) * 85);  // few levels, frequent variance ties
      1: return 8'd128;                          // flat area, every quadrant tied
      2: return $urandom_range(1) ? 8'd255 : 8'd0;
      default: return 8'($urandom);
    endcase
  endfunction

  // a whole or cut-short frame, then unless skipped the drains that flush what is owed
  task automatic run_frame(int unsigned w, int unsigned h, bit cut_short, bit skip_drain);
    int unsigned style;
    int unsigned count;
    style = $urandom_range(5);
    count = cut_short ? $urandom_range(1, w * h) : w * h;
    for (int i = 0; i < count; i++) send_item(OP_PIXEL, texture_pixel(style));
    if (!skip_drain)
      repeat (HALF * w + HALF + $urandom_range(0, 3)) send_item(OP_DRAIN, 8'($urandom));
    n_frames++;
  endtask

  task automatic test_reset_state();
    // default 640 x 480: too few pixels for any result; drains before completion do nothing
    send_item(OP_PIXEL, 8'd0);
    send_item(OP_PIXEL, 8'd255);
    send_item(OP_DRAIN, 8'd255);
    send_item(OP_PIXEL, 8'd1);
  endtask

  task automatic test_edge_sizes();
    // zero clamps to one: single-pixel frame passes straight through on a drain
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    send_item(OP_PIXEL, 8'hA5);
    send_item(OP_DRAIN, 8'd0);
    send_item(OP_DRAIN, 8'd0);
    // all ones in the register fields clamp to the maxima
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    repeat (4) send_item(OP_PIXEL, 8'($urandom));
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    write_reg(REG_IMAGE_HEIGHT, 13'd4096);
    repeat (3) send_item(OP_PIXEL, 8'($urandom));
    write_reg(REG_IMAGE_WIDTH, 13'd2048);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    repeat (3) send_item(OP_PIXEL, 8'($urandom));
  endtask

  task automatic test_smallest_kernel_frame();
    // 5 x 5: one interior pixel; a pixel arriving with outputs still owed starts afresh
    write_reg(REG_IMAGE_WIDTH, 13'd5);
    write_reg(REG_IMAGE_HEIGHT, 13'd5);
    run_frame(5, 5, 0, 1);
    run_frame(5, 5, 0, 0);
  endtask

  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    while (n_sent < 1450) begin
      steady = (n_sent > 600 && n_sent < 850);
      pick = $urandom_range(19);
      if (pick == 0) begin
        w = $urandom_range(KERNEL, 40);
        h = 2;
      end else begin
        w = $urandom_range(1, 11);
        h = $urandom_range(1, 8);
      end
      write_reg(REG_IMAGE_WIDTH, CFG_DW'(w));
      write_reg(REG_IMAGE_HEIGHT, CFG_DW'(h));
      run_frame(w, h, pick == 1, pick == 2);
      if (pick == 3) run_frame(w, h, 0, 0);
    end
    steady = 0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_IMAGE_WIDTH;
    cfg_wdata_i = '0;
    push = 1'b0;
    in_item_i = '0;
    pop = 1'b0;
    cycles = 0;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_frames_out = 0;
    n_frames = 0;
    steady = 0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    restart_frame();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_edge_sizes();
    test_smallest_kernel_frame();
    test_random_frames();

    push <= 1'b0;
    while (owed_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("sent %0d transactions over %0d frames; checked %0d pixels, %0d frame ends",
             n_sent, n_frames, n_checked, n_frames_out);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
